[hdl/svpwm_pkg.sv]
// ----------------------------------------------------------------------------
// SVPWM duty generator package
// Widths, constants, register indexes and pipeline stage records shared by
// the SVPWM min-max duty generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // Duty resolution: duties are fractions scaled by 2^DUTY_BITS (8..24)
  localparam int unsigned DUTY_BITS = 16;

  // Field widths
  localparam int unsigned VW     = 20;  // alpha / beta command
  localparam int unsigned BUSW   = 19;  // DC link voltage
  localparam int unsigned SPW    = 24;  // electrical speed
  localparam int unsigned MODW   = 16;  // modulation index limit
  localparam int unsigned FREQW  = 17;  // carrier frequency
  localparam int unsigned SPDW   = 16;  // ramp band speeds

  // Configuration port
  localparam int unsigned CFG_IDXW = 3;
  localparam int unsigned CFG_DW   = 17;

  // Fixed-point constants
  localparam logic [17:0]        FREQ_GAIN     = 18'd166886;  // 2^24/(32*pi)
  localparam logic [15:0]        INV_SQRT3_Q16 = 16'd37837;   // 2^16/sqrt(3)
  localparam logic signed [17:0] SQRT3_Q16     = 18'sd113512; // sqrt(3)*2^16
  localparam logic [BUSW-1:0]    LOW_BUS       = 19'd256;     // 1 V

  // Internal widths
  localparam int unsigned SQW    = 56;            // sqrt radicand
  localparam int unsigned ROOTW  = 28;            // vector magnitude
  localparam int unsigned VPRODW = 51;            // bus * index * 1/sqrt3
  localparam int unsigned FW     = 34;            // fundamental, Q16 of 1/16 Hz
  localparam int unsigned NUMW   = 35;            // signed ramp numerator
  localparam int unsigned SPANW  = 32;            // ramp span
  localparam int unsigned CQW    = 17;            // carrier step quotient
  localparam int unsigned CPRODW = CQW + SPANW;   // carrier step dividend
  localparam int unsigned A16W   = 28;            // command in 2^-16 V
  localparam int unsigned AQW    = 27;            // limited component magnitude
  localparam int unsigned APRODW = 2 * A16W;      // component * limit
  localparam int unsigned PHW    = 46;            // phase, scaled by 2^17
  localparam int unsigned SUMW   = PHW + 1;       // max + min
  localparam int unsigned DW     = 49;            // common-mode removed phase
  localparam int unsigned DMAGW  = DW - 1;
  localparam int unsigned DENW   = BUSW + 26 - DUTY_BITS;

  typedef enum logic [CFG_IDXW-1:0] {
    CFG_MAX_MOD_INDEX    = 3'd0,
    CFG_CARRIER_START    = 3'd1,
    CFG_CARRIER_END      = 3'd2,
    CFG_RAMP_START_SPEED = 3'd3,
    CFG_RAMP_END_SPEED   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CSEL_START = 2'd0,
    CSEL_END   = 2'd1,
    CSEL_RAMP  = 2'd2
  } csel_e;

  typedef struct packed {
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic [BUSW-1:0]      bus;
    logic [2*VW-2:0]      a2;
    logic [2*VW-2:0]      b2;
    logic [BUSW+MODW-1:0] bm;
    logic [SPW-1:0]       smag;
  } fr1_t;

  typedef struct packed {
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic [BUSW-1:0]      bus;
    logic [SQW-1:0]       x;
    logic [VPRODW-1:0]    vprod;
    logic [FW-1:0]        f;
  } fr2_t;

  typedef struct packed {
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic [BUSW-1:0]      bus;
    logic [SQW-1:0]       x;
    logic [ROOTW-1:0]     vlin;
    logic [SPANW-1:0]     num;
    logic [SPANW-1:0]     span;
    logic [CQW-1:0]       dmag;
    logic                 dneg;
    csel_e                csel;
  } fr3_t;

  typedef struct packed {
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic [BUSW-1:0]      bus;
    logic [ROOTW-1:0]     vlin;
    logic [SQW-1:0]       rem;
    logic [ROOTW-1:0]     root;
    logic [SPANW-1:0]     crem;
    logic [CQW-1:0]       cdl;
    logic [CQW-1:0]       cq;
    logic [SPANW-1:0]     span;
    logic                 dneg;
    csel_e                csel;
  } sq_t;

  typedef struct packed {
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic [BUSW-1:0]      bus;
    logic [FREQW-1:0]     carr;
    logic [ROOTW-1:0]     vmag;
    logic                 scale;
    logic [ROOTW-1:0]     arem;
    logic [AQW-1:0]       alow;
    logic [AQW-1:0]       aq;
    logic [ROOTW-1:0]     brem;
    logic [AQW-1:0]       blow;
    logic [AQW-1:0]       bq;
  } dv_t;

  typedef struct packed {
    logic [BUSW-1:0]        bus;
    logic [FREQW-1:0]       carr;
    logic signed [A16W-1:0] ap;
    logic signed [A16W-1:0] bp;
  } p0_t;

  typedef struct packed {
    logic [BUSW-1:0]       bus;
    logic [FREQW-1:0]      carr;
    logic signed [PHW-1:0] pa;
    logic signed [PHW-1:0] an16;
    logic signed [PHW-1:0] bm17;
  } p1_t;

  typedef struct packed {
    logic [BUSW-1:0]       bus;
    logic [FREQW-1:0]      carr;
    logic signed [PHW-1:0] pa;
    logic signed [PHW-1:0] pb;
    logic signed [PHW-1:0] pc;
  } p2_t;

  typedef struct packed {
    logic [BUSW-1:0]        bus;
    logic [FREQW-1:0]       carr;
    logic signed [PHW-1:0]  pa;
    logic signed [PHW-1:0]  pb;
    logic signed [PHW-1:0]  pc;
    logic signed [SUMW-1:0] sum;
  } p3_t;

  typedef struct packed {
    logic [BUSW-1:0]       bus;
    logic [FREQW-1:0]      carr;
    logic [2:0][DW-1:0]    d;
  } p4_t;

  typedef struct packed {
    logic [BUSW-1:0]       bus;
    logic [FREQW-1:0]      carr;
    logic [2:0]            neg;
    logic [2:0][DMAGW-1:0] mag;
  } p5_t;

  typedef struct packed {
    logic [BUSW-1:0]           bus;
    logic [FREQW-1:0]          carr;
    logic [2:0]                neg;
    logic [2:0]                over;
    logic [2:0][DENW-1:0]      rem;
    logic [2:0][DUTY_BITS-1:0] dl;
    logic [2:0][DUTY_BITS-1:0] q;
  } qd_t;

endpackage

[hdl/svpwm_min_max_duty_generator.sv]
// ----------------------------------------------------------------------------
// SVPWM min-max duty generator
// Fully pipelined space vector PWM duty and carrier frequency generator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive alpha/beta commands, bus voltage and speed with
//   start_i high; the item is taken at any edge where start_i is high and
//   busy_o is low. busy_o stays low: one item per clock cycle, sustained.
//   Result channel: done_o pulses for one cycle with duty_u/v/w and the
//   carrier frequency. Results leave in the order items came in.
//   Stages: each item passes 3 front stages, 29 square root stages,
//   28 vector limit divider stages, 6 phase stages, DUTY_BITS+1 duty
//   divider stages and the output register, in that order.
//   The receiver cannot stall; every result appears exactly once.
//   Configuration: cfg_valid_i/cfg_ready_o write channel, cfg_ready_o is
//   always high. Write only while no item is in flight; unknown indexes
//   are dropped.
//   Reset: clears the valid bits of every stage and loads the register
//   defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module svpwm_min_max_duty_generator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [svpwm_pkg::VW-1:0]        alpha_voltage_i,
  input  logic signed [svpwm_pkg::VW-1:0]        beta_voltage_i,
  input  logic [svpwm_pkg::BUSW-1:0]             bus_voltage_i,
  input  logic signed [svpwm_pkg::SPW-1:0]       angular_speed_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [svpwm_pkg::CFG_IDXW-1:0]         cfg_index_i,
  input  logic [svpwm_pkg::CFG_DW-1:0]           cfg_data_i,
  output logic                                   done_o,
  output logic [svpwm_pkg::DUTY_BITS-1:0]        duty_u_o,
  output logic [svpwm_pkg::DUTY_BITS-1:0]        duty_v_o,
  output logic [svpwm_pkg::DUTY_BITS-1:0]        duty_w_o,
  output logic [svpwm_pkg::FREQW-1:0]            carrier_freq_o
);

  localparam int unsigned DB   = svpwm_pkg::DUTY_BITS;
  localparam int unsigned SQN  = svpwm_pkg::ROOTW;  // one root bit per stage
  localparam int unsigned DVN  = svpwm_pkg::AQW;    // one quotient bit per stage
  localparam int unsigned QDN  = DB;                // one duty bit per stage
  localparam int unsigned LAT  = 3 + (SQN + 1) + (DVN + 1) + 6 + (QDN + 1) + 1;
  localparam logic [DB:0] HALF = (DB+1)'(1) << (DB - 1);
  localparam logic [DB:0] DMAX = ((DB+1)'(1) << DB) - (DB+1)'(1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [svpwm_pkg::MODW-1:0]  mmi_q;
  logic [svpwm_pkg::FREQW-1:0] cs_q, ce_q;
  logic [svpwm_pkg::SPDW-1:0]  rss_q, res_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mmi_q <= 16'd32768;
      cs_q  <= 17'd5000;
      ce_q  <= 17'd5000;
      rss_q <= '0;
      res_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (svpwm_pkg::cfg_idx_e'(cfg_index_i))
        svpwm_pkg::CFG_MAX_MOD_INDEX:    mmi_q <= cfg_data_i[svpwm_pkg::MODW-1:0];
        svpwm_pkg::CFG_CARRIER_START:    cs_q  <= cfg_data_i;
        svpwm_pkg::CFG_CARRIER_END:      ce_q  <= cfg_data_i;
        svpwm_pkg::CFG_RAMP_START_SPEED: rss_q <= cfg_data_i[svpwm_pkg::SPDW-1:0];
        svpwm_pkg::CFG_RAMP_END_SPEED:   res_q <= cfg_data_i[svpwm_pkg::SPDW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits, one per stage, travelling with the data
  // --------------------------------------------------------------------------
  logic [2:0]   f_v_q;
  logic [SQN:0] sq_v_q;
  logic [DVN:0] dv_v_q;
  logic [5:0]   p_v_q;
  logic [QDN:0] qd_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q  <= '0;
      sq_v_q <= '0;
      dv_v_q <= '0;
      p_v_q  <= '0;
      qd_v_q <= '0;
      done_o <= 1'b0;
    end else begin
      f_v_q  <= {f_v_q[1:0], start_i && !busy_o};
      sq_v_q <= {sq_v_q[SQN-1:0], f_v_q[2]};
      dv_v_q <= {dv_v_q[DVN-1:0], sq_v_q[SQN]};
      p_v_q  <= {p_v_q[4:0], dv_v_q[DVN]};
      qd_v_q <= {qd_v_q[QDN-1:0], p_v_q[5]};
      done_o <= qd_v_q[QDN];
    end
  end

  // --------------------------------------------------------------------------
  // Front stages: squares, limit product, fundamental frequency, ramp select
  // --------------------------------------------------------------------------
  svpwm_pkg::fr1_t f1_d, f1_q;
  svpwm_pkg::fr2_t f2_d, f2_q;
  svpwm_pkg::fr3_t f3_d, f3_q;

  always_comb begin
    logic signed [2*svpwm_pkg::VW-1:0] asq, bsq;
    asq       = alpha_voltage_i * alpha_voltage_i;
    bsq       = beta_voltage_i * beta_voltage_i;
    f1_d.a    = alpha_voltage_i;
    f1_d.b    = beta_voltage_i;
    f1_d.bus  = bus_voltage_i;
    f1_d.a2   = asq[2*svpwm_pkg::VW-2:0];
    f1_d.b2   = bsq[2*svpwm_pkg::VW-2:0];
    f1_d.bm   = 35'(bus_voltage_i) * 35'(mmi_q);
    f1_d.smag = angular_speed_i[svpwm_pkg::SPW-1] ? unsigned'(-angular_speed_i)
                                                  : unsigned'(angular_speed_i);
  end

  always_comb begin
    logic [2*svpwm_pkg::VW-1:0] msq;
    logic [41:0]                fprod;
    msq        = 40'(f1_q.a2) + 40'(f1_q.b2);
    fprod      = 42'(f1_q.smag) * 42'(svpwm_pkg::FREQ_GAIN);
    f2_d.a     = f1_q.a;
    f2_d.b     = f1_q.b;
    f2_d.bus   = f1_q.bus;
    f2_d.x     = {msq, 16'b0};
    f2_d.vprod = 51'(f1_q.bm) * 51'(svpwm_pkg::INV_SQRT3_Q16);
    f2_d.f     = fprod[41:8];
  end

  always_comb begin
    logic signed [16:0]                 rdiff;
    logic signed [17:0]                 cdiff;
    logic signed [svpwm_pkg::NUMW-1:0] num;
    logic [svpwm_pkg::SPANW-1:0]        span;
    rdiff = $signed({1'b0, res_q}) - $signed({1'b0, rss_q});
    cdiff = $signed({1'b0, ce_q}) - $signed({1'b0, cs_q});
    num   = $signed({1'b0, f2_q.f}) - $signed({3'b0, rss_q, 16'b0});
    span  = {rdiff[15:0], 16'b0};
    f3_d.a    = f2_q.a;
    f3_d.b    = f2_q.b;
    f3_d.bus  = f2_q.bus;
    f3_d.x    = f2_q.x;
    f3_d.vlin = f2_q.vprod[svpwm_pkg::VPRODW-1:23];
    f3_d.num  = num[svpwm_pkg::SPANW-1:0];
    f3_d.span = span;
    f3_d.dneg = cdiff[17];
    f3_d.dmag = cdiff[17] ? 17'(-cdiff) : cdiff[16:0];
    // Flat carrier when equal ends or a narrow band, else clip to the band edges and ramp inside it
    if (cs_q == ce_q || rdiff <= 17'sd1) begin
      f3_d.csel = svpwm_pkg::CSEL_START;
    end else if (num <= 35'sd0) begin
      f3_d.csel = svpwm_pkg::CSEL_START;
    end else if (num >= $signed({3'b0, span})) begin
      f3_d.csel = svpwm_pkg::CSEL_END;
    end else begin
      f3_d.csel = svpwm_pkg::CSEL_RAMP;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q <= f1_d;
    f2_q <= f2_d;
    f3_q <= f3_d;
  end

  // --------------------------------------------------------------------------
  // Square root pipeline: one root bit per stage; the carrier ramp division
  // runs alongside in the first CQW stages
  // --------------------------------------------------------------------------
  svpwm_pkg::sq_t sq_d [SQN+1];
  svpwm_pkg::sq_t sq_q [SQN+1];

  always_comb begin
    logic [svpwm_pkg::CPRODW-1:0] cprod;
    logic [57:0]                  t;
    logic [svpwm_pkg::SPANW:0]    ctrial;
    cprod = svpwm_pkg::CPRODW'(f3_q.dmag) * svpwm_pkg::CPRODW'(f3_q.num);
    t      = '0;
    ctrial = '0;
    sq_d[0].a    = f3_q.a;
    sq_d[0].b    = f3_q.b;
    sq_d[0].bus  = f3_q.bus;
    sq_d[0].vlin = f3_q.vlin;
    sq_d[0].rem  = f3_q.x;
    sq_d[0].root = '0;
    sq_d[0].crem = cprod[svpwm_pkg::CPRODW-1:svpwm_pkg::CQW];
    sq_d[0].cdl  = cprod[svpwm_pkg::CQW-1:0];
    sq_d[0].cq   = '0;
    sq_d[0].span = f3_q.span;
    sq_d[0].dneg = f3_q.dneg;
    sq_d[0].csel = f3_q.csel;
    for (int j = 1; j <= SQN; j++) begin
      sq_d[j] = sq_q[j-1];
      t = (58'(sq_q[j-1].root) << (SQN - j + 1)) + (58'(1) << (2 * (SQN - j)));
      if (58'(sq_q[j-1].rem) >= t) begin
        sq_d[j].rem  = sq_q[j-1].rem - t[svpwm_pkg::SQW-1:0];
        sq_d[j].root = sq_q[j-1].root | (svpwm_pkg::ROOTW'(1) << (SQN - j));
      end
      if (j <= svpwm_pkg::CQW) begin
        ctrial = {sq_q[j-1].crem, sq_q[j-1].cdl[svpwm_pkg::CQW-1]};
        sq_d[j].cdl = {sq_q[j-1].cdl[svpwm_pkg::CQW-2:0], 1'b0};
        if (ctrial >= {1'b0, sq_q[j-1].span}) begin
          ctrial        = ctrial - {1'b0, sq_q[j-1].span};
          sq_d[j].cq    = {sq_q[j-1].cq[svpwm_pkg::CQW-2:0], 1'b1};
        end else begin
          sq_d[j].cq    = {sq_q[j-1].cq[svpwm_pkg::CQW-2:0], 1'b0};
        end
        sq_d[j].crem = ctrial[svpwm_pkg::SPANW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  // --------------------------------------------------------------------------
  // Vector limit: both components times vlin over vmag, one bit per stage
  // --------------------------------------------------------------------------
  svpwm_pkg::dv_t dv_d [DVN+1];
  svpwm_pkg::dv_t dv_q [DVN+1];

  always_comb begin
    logic [svpwm_pkg::VW-1:0]     amag, bmag;
    logic [svpwm_pkg::APRODW-1:0] aprod, bprod;
    logic [svpwm_pkg::ROOTW:0]    atrial, btrial;
    amag  = sq_q[SQN].a[svpwm_pkg::VW-1] ? unsigned'(-sq_q[SQN].a) : unsigned'(sq_q[SQN].a);
    bmag  = sq_q[SQN].b[svpwm_pkg::VW-1] ? unsigned'(-sq_q[SQN].b) : unsigned'(sq_q[SQN].b);
    aprod = svpwm_pkg::APRODW'({amag, 8'b0}) * svpwm_pkg::APRODW'(sq_q[SQN].vlin);
    bprod = svpwm_pkg::APRODW'({bmag, 8'b0}) * svpwm_pkg::APRODW'(sq_q[SQN].vlin);
    atrial = '0;
    btrial = '0;
    dv_d[0].a     = sq_q[SQN].a;
    dv_d[0].b     = sq_q[SQN].b;
    dv_d[0].bus   = sq_q[SQN].bus;
    dv_d[0].vmag  = sq_q[SQN].root;
    dv_d[0].scale = sq_q[SQN].root > sq_q[SQN].vlin;
    // Quotient stays below 2^AQW, so the top bits start as the remainder
    dv_d[0].arem  = aprod[svpwm_pkg::APRODW-2:svpwm_pkg::AQW];
    dv_d[0].alow  = aprod[svpwm_pkg::AQW-1:0];
    dv_d[0].aq    = '0;
    dv_d[0].brem  = bprod[svpwm_pkg::APRODW-2:svpwm_pkg::AQW];
    dv_d[0].blow  = bprod[svpwm_pkg::AQW-1:0];
    dv_d[0].bq    = '0;
    case (sq_q[SQN].csel)
      svpwm_pkg::CSEL_END:  dv_d[0].carr = ce_q;
      svpwm_pkg::CSEL_RAMP: dv_d[0].carr = sq_q[SQN].dneg ? cs_q - sq_q[SQN].cq
                                                           : cs_q + sq_q[SQN].cq;
      default:              dv_d[0].carr = cs_q;
    endcase
    for (int j = 1; j <= DVN; j++) begin
      dv_d[j] = dv_q[j-1];
      atrial = {dv_q[j-1].arem, dv_q[j-1].alow[svpwm_pkg::AQW-1]};
      btrial = {dv_q[j-1].brem, dv_q[j-1].blow[svpwm_pkg::AQW-1]};
      dv_d[j].alow = {dv_q[j-1].alow[svpwm_pkg::AQW-2:0], 1'b0};
      dv_d[j].blow = {dv_q[j-1].blow[svpwm_pkg::AQW-2:0], 1'b0};
      if (atrial >= {1'b0, dv_q[j-1].vmag}) begin
        atrial       = atrial - {1'b0, dv_q[j-1].vmag};
        dv_d[j].aq   = {dv_q[j-1].aq[svpwm_pkg::AQW-2:0], 1'b1};
      end else begin
        dv_d[j].aq   = {dv_q[j-1].aq[svpwm_pkg::AQW-2:0], 1'b0};
      end
      if (btrial >= {1'b0, dv_q[j-1].vmag}) begin
        btrial       = btrial - {1'b0, dv_q[j-1].vmag};
        dv_d[j].bq   = {dv_q[j-1].bq[svpwm_pkg::AQW-2:0], 1'b1};
      end else begin
        dv_d[j].bq   = {dv_q[j-1].bq[svpwm_pkg::AQW-2:0], 1'b0};
      end
      dv_d[j].arem = atrial[svpwm_pkg::ROOTW-1:0];
      dv_d[j].brem = btrial[svpwm_pkg::ROOTW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
  end

  // --------------------------------------------------------------------------
  // Phase stages: inverse Clarke, min-max removal, magnitude and sign
  // --------------------------------------------------------------------------
  svpwm_pkg::p0_t p0_d, p0_q;
  svpwm_pkg::p1_t p1_d, p1_q;
  svpwm_pkg::p2_t p2_d, p2_q;
  svpwm_pkg::p3_t p3_d, p3_q;
  svpwm_pkg::p4_t p4_d, p4_q;
  svpwm_pkg::p5_t p5_d, p5_q;

  always_comb begin
    logic signed [svpwm_pkg::A16W-1:0] aqs, bqs;
    aqs = $signed({1'b0, dv_q[DVN].aq});
    bqs = $signed({1'b0, dv_q[DVN].bq});
    p0_d.bus  = dv_q[DVN].bus;
    p0_d.carr = dv_q[DVN].carr;
    if (dv_q[DVN].scale) begin
      p0_d.ap = dv_q[DVN].a[svpwm_pkg::VW-1] ? -aqs : aqs;
      p0_d.bp = dv_q[DVN].b[svpwm_pkg::VW-1] ? -bqs : bqs;
    end else begin
      p0_d.ap = $signed({dv_q[DVN].a, 8'b0});
      p0_d.bp = $signed({dv_q[DVN].b, 8'b0});
    end
  end

  always_comb begin
    logic signed [svpwm_pkg::PHW-1:0] bm;
    bm        = svpwm_pkg::SQRT3_Q16 * p0_q.bp;
    p1_d.bus  = p0_q.bus;
    p1_d.carr = p0_q.carr;
    p1_d.pa   = $signed({p0_q.ap[svpwm_pkg::A16W-1], p0_q.ap, 17'b0});
    p1_d.an16 = -$signed({{2{p0_q.ap[svpwm_pkg::A16W-1]}}, p0_q.ap, 16'b0});
    p1_d.bm17 = bm;
  end

  always_comb begin
    p2_d.bus  = p1_q.bus;
    p2_d.carr = p1_q.carr;
    p2_d.pa   = p1_q.pa;
    p2_d.pb   = p1_q.an16 + p1_q.bm17;
    p2_d.pc   = p1_q.an16 - p1_q.bm17;
  end

  always_comb begin
    logic signed [svpwm_pkg::PHW-1:0] mx, mn;
    mx = p2_q.pa;
    if (p2_q.pb > mx) mx = p2_q.pb;
    if (p2_q.pc > mx) mx = p2_q.pc;
    mn = p2_q.pa;
    if (p2_q.pb < mn) mn = p2_q.pb;
    if (p2_q.pc < mn) mn = p2_q.pc;
    p3_d.bus  = p2_q.bus;
    p3_d.carr = p2_q.carr;
    p3_d.pa   = p2_q.pa;
    p3_d.pb   = p2_q.pb;
    p3_d.pc   = p2_q.pc;
    p3_d.sum  = svpwm_pkg::SUMW'(mx) + svpwm_pkg::SUMW'(mn);
  end

  always_comb begin
    p4_d.bus  = p3_q.bus;
    p4_d.carr = p3_q.carr;
    p4_d.d[0] = unsigned'($signed({p3_q.pa, 1'b0}) - svpwm_pkg::DW'(p3_q.sum));
    p4_d.d[1] = unsigned'($signed({p3_q.pb, 1'b0}) - svpwm_pkg::DW'(p3_q.sum));
    p4_d.d[2] = unsigned'($signed({p3_q.pc, 1'b0}) - svpwm_pkg::DW'(p3_q.sum));
  end

  always_comb begin
    logic [svpwm_pkg::DW-1:0] negd;
    negd      = '0;
    p5_d.bus  = p4_q.bus;
    p5_d.carr = p4_q.carr;
    for (int i = 0; i < 3; i++) begin
      negd        = -p4_q.d[i];
      p5_d.neg[i] = p4_q.d[i][svpwm_pkg::DW-1];
      p5_d.mag[i] = p5_d.neg[i] ? negd[svpwm_pkg::DMAGW-1:0]
                                : p4_q.d[i][svpwm_pkg::DMAGW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    p1_q <= p1_d;
    p2_q <= p2_d;
    p3_q <= p3_d;
    p4_q <= p4_d;
    p5_q <= p5_d;
  end

  // --------------------------------------------------------------------------
  // Duty division by bus << (26 - DUTY_BITS), one bit per stage
  // --------------------------------------------------------------------------
  svpwm_pkg::qd_t qd_d [QDN+1];
  svpwm_pkg::qd_t qd_q [QDN+1];

  always_comb begin
    logic [svpwm_pkg::DENW-1:0]  den0, den;
    logic [svpwm_pkg::DMAGW-1:0] sh;
    logic [svpwm_pkg::DENW:0]    trial;
    den0  = {p5_q.bus, (26 - DB)'(0)};
    den   = '0;
    sh    = '0;
    trial = '0;
    qd_d[0].bus  = p5_q.bus;
    qd_d[0].carr = p5_q.carr;
    qd_d[0].neg  = p5_q.neg;
    qd_d[0].q    = '0;
    for (int i = 0; i < 3; i++) begin
      sh = p5_q.mag[i] >> DB;
      qd_d[0].over[i] = sh >= svpwm_pkg::DMAGW'(den0);
      qd_d[0].rem[i]  = sh[svpwm_pkg::DENW-1:0];
      qd_d[0].dl[i]   = p5_q.mag[i][DB-1:0];
    end
    for (int j = 1; j <= QDN; j++) begin
      qd_d[j] = qd_q[j-1];
      den = {qd_q[j-1].bus, (26 - DB)'(0)};
      for (int i = 0; i < 3; i++) begin
        trial = {qd_q[j-1].rem[i], qd_q[j-1].dl[i][DB-1]};
        qd_d[j].dl[i] = {qd_q[j-1].dl[i][DB-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          trial         = trial - {1'b0, den};
          qd_d[j].q[i]  = {qd_q[j-1].q[i][DB-2:0], 1'b1};
        end else begin
          qd_d[j].q[i]  = {qd_q[j-1].q[i][DB-2:0], 1'b0};
        end
        qd_d[j].rem[i] = trial[svpwm_pkg::DENW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qd_q <= qd_d;
  end

  // --------------------------------------------------------------------------
  // Output: floor, offset by one half, clamp; low bus forces one half
  // --------------------------------------------------------------------------
  logic [2:0][DB-1:0] duty_d;

  always_comb begin
    logic [DB:0] v;
    v = '0;
    for (int i = 0; i < 3; i++) begin
      if (qd_q[QDN].bus <= svpwm_pkg::LOW_BUS) begin
        duty_d[i] = HALF[DB-1:0];
      end else if (qd_q[QDN].over[i]) begin
        duty_d[i] = qd_q[QDN].neg[i] ? '0 : DMAX[DB-1:0];
      end else if (!qd_q[QDN].neg[i]) begin
        v = HALF + (DB+1)'(qd_q[QDN].q[i]);
        duty_d[i] = (v > DMAX) ? DMAX[DB-1:0] : v[DB-1:0];
      end else begin
        // Round the magnitude up so the quotient floors toward minus infinity
        v = (DB+1)'(qd_q[QDN].q[i]) + (DB+1)'(qd_q[QDN].rem[i] != '0);
        v = (v > HALF) ? '0 : HALF - v;
        duty_d[i] = v[DB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    duty_u_o       <= duty_d[0];
    duty_v_o       <= duty_d[1];
    duty_w_o       <= duty_d[2];
    carrier_freq_o <= qd_q[QDN].carr;
  end

`ifndef SYNTHESIS
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without an item accepted LAT cycles earlier");

  a_carrier_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((carrier_freq_o >= cs_q && carrier_freq_o <= ce_q) ||
                (carrier_freq_o >= ce_q && carrier_freq_o <= cs_q)))
    else $error("carrier outside the configured range");

  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q[SQN] |-> (57'(sq_q[SQN].rem) <= 57'({sq_q[SQN].root, 1'b0})))
    else $error("square root remainder too large");

  a_duty_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qd_v_q[QDN] && !qd_q[QDN].over[0]) |->
      (qd_q[QDN].rem[0] < {qd_q[QDN].bus, (26 - DB)'(0)}))
    else $error("duty divider remainder not below divisor");
`endif

endmodule

[tb/svpwm_duty_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SVPWM duty checker
// Watches the item, configuration and result channels of the SVPWM min-max
// duty generator. It predicts duties and carrier per accepted item and
// compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
module svpwm_duty_checker
  import svpwm_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic signed [VW-1:0]        alpha_voltage_i,
  input  logic signed [VW-1:0]        beta_voltage_i,
  input  logic [BUSW-1:0]             bus_voltage_i,
  input  logic signed [SPW-1:0]       angular_speed_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CFG_IDXW-1:0]         cfg_index_i,
  input  logic [CFG_DW-1:0]           cfg_data_i,
  input  logic                        done_i,
  input  logic [DUTY_BITS-1:0]        duty_u_i,
  input  logic [DUTY_BITS-1:0]        duty_v_i,
  input  logic [DUTY_BITS-1:0]        duty_w_i,
  input  logic [FREQW-1:0]            carrier_freq_i,
  output int                          pending_o,
  output int                          fails_o
);

  typedef struct {
    logic [DUTY_BITS-1:0] u;
    logic [DUTY_BITS-1:0] v;
    logic [DUTY_BITS-1:0] w;
    logic [FREQW-1:0]     carr;
  } duty_set_t;

  duty_set_t expected_duties[$];

  logic [MODW-1:0]  mod_limit;
  logic [FREQW-1:0] carr_lo;
  logic [FREQW-1:0] carr_hi;
  logic [SPDW-1:0]  band_lo;
  logic [SPDW-1:0]  band_hi;
  int               fails;

  assign fails_o   = fails;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Floor division, then offset by one half and saturate
  function automatic logic [DUTY_BITS-1:0] to_duty(longint d, longint den);
    longint q;
    longint v;
    q = d / den;
    if ((d % den) != 0 && (d < 0)) q = q - 1;
    v = (longint'(1) << (DUTY_BITS - 1)) + q;
    if (v < 0) v = 0;
    if (v > (longint'(1) << DUTY_BITS) - 1) v = (longint'(1) << DUTY_BITS) - 1;
    return v[DUTY_BITS-1:0];
  endfunction

  function automatic logic [FREQW-1:0] speed_to_carrier(longint speed);
    longint s;
    longint e;
    longint r;
    longint f;
    longint num;
    longint span;
    s = carr_lo;
    e = carr_hi;
    r = longint'(band_hi) - longint'(band_lo);
    if (s == e || r <= 1) return carr_lo;
    f    = ((speed < 0 ? -speed : speed) * 166886) >>> 8;
    num  = f - (longint'(band_lo) << 16);
    span = r << 16;
    if (num <= 0) return carr_lo;
    if (num >= span) return carr_hi;
    return FREQW'(s + ((e - s) * num) / span);
  endfunction

  function automatic duty_set_t predict_duties(longint a, longint b, longint bus,
                                               longint speed);
    duty_set_t       res;
    longint unsigned vmag;
    longint          vlin;
    longint          a16;
    longint          b16;
    longint          pa;
    longint          pb;
    longint          pc;
    longint          mx;
    longint          mn;
    longint          den;
    res.carr = speed_to_carrier(speed);
    if (bus <= 256) begin
      res.u = DUTY_BITS'(1) << (DUTY_BITS - 1);
      res.v = res.u;
      res.w = res.u;
      return res;
    end
    vmag = int_sqrt(longint'(a * a + b * b) << 16);
    vlin = (bus * longint'(mod_limit) * 37837) >>> 23;
    a16  = a * 256;
    b16  = b * 256;
    // Scale the vector down onto the linear limit
    if (longint'(vmag) > vlin) begin
      a16 = (a16 * vlin) / longint'(vmag);
      b16 = (b16 * vlin) / longint'(vmag);
    end
    pa = a16 * 131072;
    pb = -a16 * 65536 + 113512 * b16;
    pc = -a16 * 65536 - 113512 * b16;
    mx = pa;
    if (pb > mx) mx = pb;
    if (pc > mx) mx = pc;
    mn = pa;
    if (pb < mn) mn = pb;
    if (pc < mn) mn = pc;
    den   = bus << (26 - DUTY_BITS);
    res.u = to_duty(2 * pa - (mx + mn), den);
    res.v = to_duty(2 * pb - (mx + mn), den);
    res.w = to_duty(2 * pc - (mx + mn), den);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    duty_set_t want;
    if (!rst_ni) begin
      mod_limit <= 16'd32768;
      carr_lo   <= 17'd5000;
      carr_hi   <= 17'd5000;
      band_lo   <= '0;
      band_hi   <= '0;
      fails     = 0;
      expected_duties.delete();
      pending_o = 0;
    end else begin
      if (start_i && !busy_i)
        expected_duties.push_back(predict_duties(alpha_voltage_i, beta_voltage_i,
                                                 bus_voltage_i, angular_speed_i));
      if (done_i) begin
        if (expected_duties.size() == 0) begin
          report_mismatch("done with no item outstanding", 1, 0);
        end else begin
          want = expected_duties.pop_front();
          if (duty_u_i !== want.u) report_mismatch("duty_u", duty_u_i, want.u);
          if (duty_v_i !== want.v) report_mismatch("duty_v", duty_v_i, want.v);
          if (duty_w_i !== want.w) report_mismatch("duty_w", duty_w_i, want.w);
          if (carrier_freq_i !== want.carr)
            report_mismatch("carrier_freq", carrier_freq_i, want.carr);
        end
      end
      pending_o = expected_duties.size();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MAX_MOD_INDEX:    mod_limit <= cfg_data_i[MODW-1:0];
          CFG_CARRIER_START:    carr_lo   <= cfg_data_i[FREQW-1:0];
          CFG_CARRIER_END:      carr_hi   <= cfg_data_i[FREQW-1:0];
          CFG_RAMP_START_SPEED: band_lo   <= cfg_data_i[SPDW-1:0];
          CFG_RAMP_END_SPEED:   band_hi   <= cfg_data_i[SPDW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[tb/tb_svpwm_min_max_duty_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SVPWM min-max duty generator testbench
// Drives directed and random voltage commands through several register
// settings, with random gaps between items; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_svpwm_min_max_duty_generator;
  import svpwm_pkg::*;

  localparam int DRAIN_CYCLES = 100;  // extra wait after the checker's queue empties

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic signed [VW-1:0]  alpha_voltage_i;
  logic signed [VW-1:0]  beta_voltage_i;
  logic [BUSW-1:0]       bus_voltage_i;
  logic signed [SPW-1:0] angular_speed_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDXW-1:0]   cfg_index_i;
  logic [CFG_DW-1:0]     cfg_data_i;
  logic                  done_o;
  logic [DUTY_BITS-1:0]  duty_u_o;
  logic [DUTY_BITS-1:0]  duty_v_o;
  logic [DUTY_BITS-1:0]  duty_w_o;
  logic [FREQW-1:0]      carrier_freq_o;
  int                    pending;
  int                    fails;

  // Band edges as last written, used to aim speeds at the ramp
  int unsigned band_lo;
  int unsigned band_hi;
  int          gap_mode;

  svpwm_min_max_duty_generator dut (.*);

  svpwm_duty_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .alpha_voltage_i, .beta_voltage_i, .bus_voltage_i, .angular_speed_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .done_i(done_o), .duty_u_i(duty_u_o), .duty_v_i(duty_v_o),
    .duty_w_i(duty_w_o), .carrier_freq_i(carrier_freq_o),
    .pending_o(pending), .fails_o(fails)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Drop the run if it hangs
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // Drive one item at the falling edge and hold it until taken. Start stays
  // high when the next item follows with no gap.
  task automatic send_item(int a, int b, int bus, int speed, int gap);
    @(negedge clk_i);
    start_i         = 1'b1;
    alpha_voltage_i = VW'(a);
    beta_voltage_i  = VW'(b);
    bus_voltage_i   = BUSW'(bus);
    angular_speed_i = SPW'(speed);
    do @(posedge clk_i); while (busy_o);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = CFG_DW'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == CFG_RAMP_START_SPEED) band_lo = data & 16'hFFFF;
    if (idx == CFG_RAMP_END_SPEED) band_hi = data & 16'hFFFF;
  endtask

  // Wait for the pipeline to empty before touching the registers
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_regs(int unsigned mi, int unsigned cs, int unsigned ce,
                          int unsigned rs, int unsigned re);
    drain();
    write_reg(CFG_MAX_MOD_INDEX, mi);
    write_reg(CFG_CARRIER_START, cs);
    write_reg(CFG_CARRIER_END, ce);
    write_reg(CFG_RAMP_START_SPEED, rs);
    write_reg(CFG_RAMP_END_SPEED, re);
  endtask

  function automatic int pick_gap();
    int r;
    if (gap_mode == 0) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Speeds aimed at the band edges, inside the band, or anywhere
  function automatic int pick_speed();
    int s;
    case ($urandom_range(4))
      0: s = $signed($urandom()) >>> 8;
      1: s = band_lo * 101 + $urandom_range(400) - 200;
      2: s = band_hi * 100 + $urandom_range(400) - 200;
      default: s = $urandom_range(band_hi * 101 + 1000);
    endcase
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    if ($urandom_range(1) != 0 && s > -8388608) s = -s;
    return s;
  endfunction

  function automatic int pick_volt();
    case ($urandom_range(2))
      0: return $signed($urandom()) >>> 12;
      1: return $signed($urandom()) >>> 20;
      default: return $signed($urandom()) >>> 15;
    endcase
  endfunction

  function automatic int pick_bus();
    case ($urandom_range(5))
      0: return $urandom_range(300);
      1: return $urandom_range(524287);
      default: return $urandom_range(60000, 257);
    endcase
  endfunction

  task automatic random_items(int n);
    repeat (n) send_item(pick_volt(), pick_volt(), pick_bus(), pick_speed(), pick_gap());
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    alpha_voltage_i = '0;
    beta_voltage_i  = '0;
    bus_voltage_i   = '0;
    angular_speed_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_MAX_MOD_INDEX;
    cfg_data_i      = '0;
    band_lo         = 0;
    band_hi         = 0;
    gap_mode        = 1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults: equal carriers, so the carrier never moves
    send_item(524287, 524287, 524287, 8388607, 0);
    send_item(-524288, -524288, 524287, -8388608, 0);
    send_item(1000, -2000, 256, 0, 1);
    send_item(1000, -2000, 257, 0, 0);
    send_item(1000, -2000, 0, 12345, 0);
    send_item(100, 50, 100000, 500, 2);   // well inside the limit
    send_item(0, 0, 524287, 0, 0);
    send_item(-524288, 0, 300, 1, 0);     // heavily limited
    random_items(250);

    // Ramp band 100..2000 (units of 1/16 Hz)
    set_regs(32768, 2000, 20000, 100, 2000);
    send_item(5000, 3000, 20000, 0, 0);        // below the band
    send_item(5000, 3000, 20000, 10000, 0);
    send_item(5000, 3000, 20000, 100000, 0);   // inside the band
    send_item(5000, 3000, 20000, -150000, 0);
    send_item(5000, 3000, 20000, 202000, 0);   // above the band
    send_item(5000, 3000, 20000, -8388608, 0);
    send_item(0, 524287, 40000, 8388607, 0);
    random_items(300);

    // Full index overdrives the vector into duty saturation; narrow band;
    // unknown indexes must be dropped
    set_regs(65535, 100000, 0, 5000, 5001);
    write_reg(cfg_idx_e'(5), 17'h1FFFF);
    write_reg(cfg_idx_e'(7), 17'h0ABCD);
    send_item(524287, 0, 1000, 505000, 0);
    send_item(0, -524288, 1000, 0, 0);
    send_item(-300000, 200000, 800, 8388607, 0);
    gap_mode = 0;
    random_items(300);
    gap_mode = 1;

    // Zero index, reversed band; bit 16 of the index data is ignored
    set_regs(32'h10000, 0, 100000, 65535, 0);
    send_item(400000, -400000, 524287, 8388607, 0);
    random_items(300);

    // Widest band
    set_regs(16384, 8000, 12000, 0, 65535);
    send_item(1, -1, 257, 6619000, 0);
    random_items(350);

    set_regs($urandom_range(65535), $urandom_range(100000), $urandom_range(100000),
             $urandom_range(2000), $urandom_range(60000, 2000));
    random_items(350);

    drain();
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[svpwm_min_max_duty_generator.f]
hdl/svpwm_pkg.sv
hdl/svpwm_min_max_duty_generator.sv
tb/svpwm_duty_checker.sv
tb/tb_svpwm_min_max_duty_generator.sv
